// ===== rtl/smspg_pkg.sv =====
package smspg_pkg;

	localparam int SINE_DEPTH_DEF = 1024;

	// register map
	typedef enum logic [2:0] {
		REG_PHASE_INC       = 3'd0,
		REG_AMPLITUDE       = 3'd1,
		REG_STEPS_PER_ROUND = 3'd2,
		REG_START_DIR       = 3'd3,
		REG_ROUND_COUNT     = 3'd4,
		REG_BASE_INTERVAL   = 3'd5
	} reg_idx_t;

	localparam logic [31:0]        PHASE_INC_RST  = 32'd198841;
	localparam logic signed [15:0] AMPLITUDE_RST  = 16'sd500;
	localparam logic [31:0]        STEPS_RND_RST  = 32'd55000;
	localparam logic               START_DIR_RST  = 1'b1;
	localparam logic [15:0]        ROUND_CNT_RST  = 16'd2;
	localparam logic [15:0]        BASE_INTV_RST  = 16'd150;

	typedef struct packed {
		logic [31:0]        phase_increment;
		logic signed [15:0] amplitude;
		logic [31:0]        steps_per_round;
		logic               start_direction;
		logic [15:0]        round_count;
		logic [15:0]        base_interval;
	} cfg_t;

	// restart request with the values that take effect with it
	typedef struct packed {
		logic        restart;
		logic [15:0] round_count;
		logic        start_direction;
	} restart_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LATCH,
		OP_START,
		OP_ROUND,
		OP_PHASE,
		OP_KIDX,
		OP_ROM,
		OP_AMUL,
		OP_INTV,
		OP_FIRE,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_IN,
		C_DONE,
		C_OUT_BUSY
	} cond_t;

	typedef logic [3:0] step_t;

	localparam step_t ST_WAIT  = 4'd0;
	localparam step_t ST_START = 4'd1;
	localparam step_t ST_ROUND = 4'd2;
	localparam step_t ST_PHASE = 4'd3;
	localparam step_t ST_KIDX  = 4'd4;
	localparam step_t ST_ROM   = 4'd5;
	localparam step_t ST_AMUL  = 4'd6;
	localparam step_t ST_INTV  = 4'd7;
	localparam step_t ST_FIRE  = 4'd8;
	localparam step_t ST_EMIT  = 4'd9;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t jmp;
		step_t nxt;
	} uword_t;

	typedef struct packed {
		logic in_valid;
		logic done;
		logic out_busy;
	} seq_status_t;

	// microprogram: next step is jmp when cond holds, nxt otherwise
	function automatic uword_t ucode(step_t s);
		uword_t w;
		w = '{op: OP_NOP, cond: C_ALWAYS, jmp: ST_WAIT, nxt: ST_WAIT};
		unique case (s)
			ST_WAIT:  w = '{op: OP_LATCH, cond: C_NO_IN,    jmp: ST_WAIT, nxt: ST_START};
			ST_START: w = '{op: OP_START, cond: C_DONE,     jmp: ST_EMIT, nxt: ST_ROUND};
			ST_ROUND: w = '{op: OP_ROUND, cond: C_NEVER,    jmp: ST_WAIT, nxt: ST_PHASE};
			ST_PHASE: w = '{op: OP_PHASE, cond: C_DONE,     jmp: ST_EMIT, nxt: ST_KIDX};
			ST_KIDX:  w = '{op: OP_KIDX,  cond: C_NEVER,    jmp: ST_WAIT, nxt: ST_ROM};
			ST_ROM:   w = '{op: OP_ROM,   cond: C_NEVER,    jmp: ST_WAIT, nxt: ST_AMUL};
			ST_AMUL:  w = '{op: OP_AMUL,  cond: C_NEVER,    jmp: ST_WAIT, nxt: ST_INTV};
			ST_INTV:  w = '{op: OP_INTV,  cond: C_NEVER,    jmp: ST_WAIT, nxt: ST_FIRE};
			ST_FIRE:  w = '{op: OP_FIRE,  cond: C_NEVER,    jmp: ST_WAIT, nxt: ST_EMIT};
			ST_EMIT:  w = '{op: OP_EMIT,  cond: C_OUT_BUSY, jmp: ST_EMIT, nxt: ST_WAIT};
			default:  w = '{op: OP_NOP,   cond: C_ALWAYS,   jmp: ST_WAIT, nxt: ST_WAIT};
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/smspg_cfg.sv =====
module smspg_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	output smspg_pkg::cfg_t     cfg,
	output smspg_pkg::restart_t rst_info
);
	import smspg_pkg::*;

	cfg_t cfg_q;
	logic wr;
	logic hit;

	assign cfg_ready = 1'b1;
	assign wr        = cfg_valid && cfg_ready;
	assign hit       = cfg_index <= REG_BASE_INTERVAL;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_increment <= PHASE_INC_RST;
			cfg_q.amplitude       <= AMPLITUDE_RST;
			cfg_q.steps_per_round <= STEPS_RND_RST;
			cfg_q.start_direction <= START_DIR_RST;
			cfg_q.round_count     <= ROUND_CNT_RST;
			cfg_q.base_interval   <= BASE_INTV_RST;
		end else if (wr) begin
			unique case (reg_idx_t'(cfg_index))
				REG_PHASE_INC:       cfg_q.phase_increment <= cfg_data;
				REG_AMPLITUDE:       cfg_q.amplitude       <= $signed(cfg_data[15:0]);
				REG_STEPS_PER_ROUND: cfg_q.steps_per_round <= cfg_data;
				REG_START_DIR:       cfg_q.start_direction <= cfg_data[0];
				REG_ROUND_COUNT:     cfg_q.round_count     <= cfg_data[15:0];
				REG_BASE_INTERVAL:   cfg_q.base_interval   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

	// restart uses the value being written in the same transfer
	always_comb begin
		rst_info.restart         = wr && hit;
		rst_info.round_count     = cfg_q.round_count;
		rst_info.start_direction = cfg_q.start_direction;
		if (reg_idx_t'(cfg_index) == REG_ROUND_COUNT)
			rst_info.round_count = cfg_data[15:0];
		if (reg_idx_t'(cfg_index) == REG_START_DIR)
			rst_info.start_direction = cfg_data[0];
	end

endmodule

// ===== rtl/smspg_useq.sv =====
module smspg_useq (
	input  logic                   clk,
	input  logic                   arst_n,
	input  smspg_pkg::seq_status_t st,
	output smspg_pkg::uword_t      ctl
);
	import smspg_pkg::*;

	step_t step_q;
	logic  take;

	assign ctl = ucode(step_q);

	always_comb begin
		unique case (ctl.cond)
			C_NEVER:    take = 1'b0;
			C_ALWAYS:   take = 1'b1;
			C_NO_IN:    take = !st.in_valid;
			C_DONE:     take = st.done;
			C_OUT_BUSY: take = st.out_busy;
			default:    take = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_WAIT;
		end else begin
			step_q <= take ? ctl.jmp : ctl.nxt;
		end
	end

endmodule

// ===== rtl/smspg_dp.sv =====
module smspg_dp #(
	parameter int SINE_DEPTH = smspg_pkg::SINE_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  smspg_pkg::uword_t      ctl,
	input  smspg_pkg::cfg_t        cfg,
	input  smspg_pkg::restart_t    rst_info,
	input  logic                   in_valid,
	input  logic [31:0]            now_ms,
	input  logic                   out_ready,
	output logic                   out_valid,
	output logic                   step_pulse,
	output logic                   dir_level,
	output logic [31:0]            steps_in_round,
	output logic signed [17:0]     interval_ms,
	output logic                   finished,
	output logic                   done,
	output logic                   out_busy
);
	import smspg_pkg::*;

	localparam int AW = $clog2(SINE_DEPTH);
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] ONE_Q30     = 64'd1073741824;
	localparam logic [63:0] SERIES_DIV [5] = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
	localparam logic [AW:0] DEPTH_W = (AW+1)'(SINE_DEPTH);

	typedef logic [14:0] rom_t [SINE_DEPTH];

	// quarter sine in Q15, fixed-point series evaluated at elaboration
	function automatic rom_t build_rom();
		rom_t        r;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		for (int i = 0; i < SINE_DEPTH; i++) begin
			x  = (64'(i) * HALF_PI_Q30) / SINE_DEPTH;
			x2 = (x * x) >> 30;
			t  = ONE_Q30;
			for (int j = 0; j < 5; j++)
				t = ONE_Q30 - ((x2 * t) >> 30) / SERIES_DIV[j];
			s = (x * t) >> 30;
			s = (s + 64'd16384) >> 15;
			if (s > 64'd32767)
				s = 64'd32767;
			r[i] = s[14:0];
		end
		return r;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	// item state
	logic               running_q;
	logic               done_q;
	logic [31:0]        now_q;
	logic [31:0]        start_q;
	logic [31:0]        last_q;
	logic [31:0]        idx_q;
	logic [15:0]        rounds_q;
	logic               dir_q;

	// working registers
	logic [31:0]        elapsed_q;
	logic [31:0]        gap_q;
	logic [31:0]        phase_q;
	logic [1:0]         quad_q;
	logic [AW-1:0]      k_q;
	logic [14:0]        rom_q;
	logic               full_q;
	logic               neg_q;
	logic signed [32:0] prod_q;
	logic signed [17:0] interval_q;
	logic               pulse_q;

	logic [AW+30:0]     kprod;
	logic [AW:0]        addr;
	logic               addr_full;
	logic [AW-1:0]      ridx;
	logic [14:0]        qval;
	logic signed [16:0] sine_v;
	logic signed [32:0] biased;
	logic signed [16:0] var_v;
	logic signed [17:0] interval_d;
	logic [31:0]        interval_w;

	assign kprod     = (AW+31)'(phase_q[29:0]) * (AW+31)'(SINE_DEPTH);
	assign addr      = quad_q[0] ? DEPTH_W - {1'b0, k_q} : {1'b0, k_q};
	assign addr_full = addr == DEPTH_W;
	assign ridx      = addr_full ? '0 : addr[AW-1:0];

	assign qval   = full_q ? 15'h7fff : rom_q;
	assign sine_v = neg_q ? -$signed({2'b00, qval}) : $signed({2'b00, qval});

	// divide by 2^15 rounding toward zero
	assign biased     = prod_q + (prod_q[32] ? 33'sd32767 : 33'sd0);
	assign var_v      = 17'(biased >>> 15);
	assign interval_d = $signed({2'b00, cfg.base_interval}) + {var_v[16], var_v};
	assign interval_w = {{14{interval_q[17]}}, interval_q};

	assign out_busy = out_valid && !out_ready;
	assign done     = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			done_q    <= 1'b0;
			idx_q     <= '0;
			rounds_q  <= ROUND_CNT_RST;
			dir_q     <= START_DIR_RST;
			start_q   <= '0;
			last_q    <= '0;
			pulse_q   <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			// output register: load on emit, otherwise clear once taken
			if (ctl.op == OP_EMIT && !out_busy)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
			if (rst_info.restart) begin
				running_q <= 1'b0;
				done_q    <= 1'b0;
				idx_q     <= '0;
				rounds_q  <= rst_info.round_count;
				dir_q     <= rst_info.start_direction;
				start_q   <= '0;
				last_q    <= '0;
			end else begin
				unique case (ctl.op)
					OP_START: begin
						pulse_q <= 1'b0;
						if (!done_q && !running_q) begin
							running_q <= 1'b1;
							start_q   <= now_q;
							last_q    <= now_q;
							idx_q     <= '0;
						end
					end
					OP_ROUND: begin
						if (idx_q >= cfg.steps_per_round) begin
							if (rounds_q > 16'd1) begin
								idx_q    <= '0;
								dir_q    <= !dir_q;
								rounds_q <= rounds_q - 16'd1;
							end else begin
								done_q <= 1'b1;
							end
						end
					end
					OP_FIRE: begin
						if (gap_q >= interval_w) begin
							pulse_q <= 1'b1;
							last_q  <= now_q;
							idx_q   <= idx_q + 32'd1;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (ctl.op)
			OP_LATCH: if (in_valid) now_q <= now_ms;
			OP_START: interval_q <= '0;
			OP_ROUND: begin
				elapsed_q <= now_q - start_q;
				gap_q     <= now_q - last_q;
			end
			OP_PHASE: phase_q <= cfg.phase_increment * elapsed_q;
			OP_KIDX: begin
				k_q    <= kprod[AW+29:30];
				quad_q <= phase_q[31:30];
			end
			OP_ROM: begin
				rom_q  <= SINE_ROM[ridx];
				full_q <= addr_full;
				neg_q  <= quad_q[1];
			end
			OP_AMUL: prod_q <= $signed(cfg.amplitude) * sine_v;
			OP_INTV: interval_q <= interval_d;
			OP_EMIT: begin
				if (!out_busy) begin
					step_pulse     <= pulse_q;
					dir_level      <= dir_q;
					steps_in_round <= idx_q;
					interval_ms    <= interval_q;
					finished       <= done_q;
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== rtl/sine_modulated_step_pulse_generator.sv =====
// Step pulse generator whose step interval follows a sine of elapsed time.
// Each input transfer carries the millisecond clock; each one yields exactly
// one result transfer with the step decision, direction, step count, the
// computed interval and the finished flag. A small microprogram sequences a
// shared datapath: each item runs from its input transfer to its result
// entering the output register through one step each for start, round check,
// phase multiply, table index multiply, registered sine ROM read, amplitude
// multiply, interval add, compare and emit, and the emit step holds while the
// previous result is not yet taken. The item on which the rounds run out and
// every later item skip the remaining steps straight to emit. A new item is
// taken on the cycle after emit, so the block takes no new item while one is
// in work. The configuration port is always ready; any write to a defined
// register restarts the run (start time relatched on the next item, rounds
// and direction reloaded).
module sine_modulated_step_pulse_generator #(
	parameter int SINE_DEPTH = smspg_pkg::SINE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [31:0]        now_ms,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               step_pulse,
	output logic               dir_level,
	output logic [31:0]        steps_in_round,
	output logic signed [17:0] interval_ms,
	output logic               finished
);
	import smspg_pkg::*;

	cfg_t        cfg;
	restart_t    rst_info;
	uword_t      ctl;
	seq_status_t st;
	logic        done;
	logic        out_busy;

	assign in_ready    = ctl.op == OP_LATCH;
	assign st.in_valid = in_valid;
	assign st.done     = done;
	assign st.out_busy = out_busy;

	smspg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.rst_info  (rst_info)
	);

	smspg_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.ctl    (ctl)
	);

	smspg_dp #(
		.SINE_DEPTH (SINE_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.cfg            (cfg),
		.rst_info       (rst_info),
		.in_valid       (in_valid),
		.now_ms         (now_ms),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.step_pulse     (step_pulse),
		.dir_level      (dir_level),
		.steps_in_round (steps_in_round),
		.interval_ms    (interval_ms),
		.finished       (finished),
		.done           (done),
		.out_busy       (out_busy)
	);

	// a finished result never carries a step or an interval
	a_finished_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && finished |-> !step_pulse && interval_ms == 18'sd0)
		else $error("finished result carries step or interval");

	// a write to a defined register always clears the finished state
	a_write_clears_done: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && cfg_index <= REG_BASE_INTERVAL |=> !done)
		else $error("finished state survived a register write");

	// after an input transfer the sequencer is busy with that item
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in work");

endmodule

// ===== bench/smspg_checker.sv =====
`timescale 1ns / 100ps
module smspg_checker
	import smspg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [31:0]        now_ms,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic               step_pulse,
	input  logic               dir_level,
	input  logic [31:0]        steps_in_round,
	input  logic signed [17:0] interval_ms,
	input  logic               finished,
	output int                 fail_count,
	output int                 open_count
);

	localparam int DEPTH = SINE_DEPTH_DEF;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned ONE_Q30 = 64'd1073741824;

	typedef struct packed {
		logic        pulse;
		logic        dir;
		logic [31:0] steps;
		logic [17:0] interval;
		logic        done;
	} step_result_t;

	logic [15:0] quarter_rom [DEPTH];

	logic [31:0]        p_phase_inc;
	logic signed [15:0] p_amp;
	logic [31:0]        p_steps_per_round;
	logic               p_start_dir;
	logic [15:0]        p_round_count;
	logic [15:0]        p_base;

	logic        run_r;
	logic [31:0] start_r;
	logic [31:0] last_r;
	logic [31:0] idx_r;
	logic [15:0] rounds_r;
	logic        dir_r;
	logic        done_r;

	step_result_t expected_q [$];
	int errs = 0;

	// quarter-wave table: odd power series in Q30, rounded to Q15
	initial begin
		longint unsigned x, x2, t, s;
		int n;
		for (int i = 0; i < DEPTH; i++) begin
			x = (64'(i) * HALF_PI_Q30) / 64'(DEPTH);
			x2 = (x * x) >> 30;
			t = ONE_Q30;
			for (n = 11; n > 1; n -= 2)
				t = ONE_Q30 - ((x2 * t) >> 30) / (n * (n - 1));
			s = (x * t) >> 30;
			s = (s + 64'd16384) >> 15;
			quarter_rom[i] = (s > 64'd32767) ? 16'd32767 : s[15:0];
		end
	end

	function automatic int sine_of(input logic [31:0] ph);
		longint unsigned frac, k;
		int mag;
		frac = ph[29:0];
		k = (frac * DEPTH) >> 30;
		// quadrants 1 and 3 run the table backwards, 2 and 3 are negative
		if (ph[30])
			k = DEPTH - k;
		mag = (k >= DEPTH) ? 32767 : int'(quarter_rom[k]);
		return ph[31] ? -mag : mag;
	endfunction

	function automatic void restart_run();
		run_r = 1'b0;
		done_r = 1'b0;
		start_r = '0;
		last_r = '0;
		idx_r = '0;
		rounds_r = p_round_count;
		dir_r = p_start_dir;
	endfunction

	function automatic step_result_t next_step_decision(input logic [31:0] t);
		step_result_t r;
		logic [31:0] phase, since_step, need;
		int offset, span;
		r = '0;
		if (!done_r) begin
			if (!run_r) begin
				run_r = 1'b1;
				start_r = t;
				last_r = t;
				idx_r = '0;
			end
			if (idx_r >= p_steps_per_round) begin
				if (rounds_r > 16'd1) begin
					idx_r = '0;
					dir_r = ~dir_r;
					rounds_r = rounds_r - 16'd1;
				end else
					done_r = 1'b1;
			end
		end
		if (!done_r) begin
			phase = p_phase_inc * (t - start_r);
			offset = (int'(p_amp) * sine_of(phase)) / 32768;
			span = int'(p_base) + offset;
			// unsigned compare: a negative interval only fires on a near-full wrap
			need = span;
			since_step = t - last_r;
			if (since_step >= need) begin
				r.pulse = 1'b1;
				last_r = t;
				idx_r++;
			end
			r.interval = span[17:0];
		end
		r.dir = dir_r;
		r.steps = idx_r;
		r.done = done_r;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			errs++;
			$display("%0t smspg_checker: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		step_result_t want;
		if (!arst_n) begin
			p_phase_inc = PHASE_INC_RST;
			p_amp = AMPLITUDE_RST;
			p_steps_per_round = STEPS_RND_RST;
			p_start_dir = START_DIR_RST;
			p_round_count = ROUND_CNT_RST;
			p_base = BASE_INTV_RST;
			restart_run();
			expected_q.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					errs++;
					$display("%0t smspg_checker: result transfer with nothing expected, got pulse %0d steps %0d",
						$time, step_pulse, steps_in_round);
				end else begin
					want = expected_q.pop_front();
					check_field("step_pulse", want.pulse, step_pulse);
					check_field("dir_level", want.dir, dir_level);
					check_field("steps_in_round", want.steps, steps_in_round);
					check_field("interval_ms", want.interval, {14'd0, interval_ms});
					check_field("finished", want.done, finished);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PHASE_INC:       p_phase_inc = cfg_data;
					REG_AMPLITUDE:       p_amp = cfg_data[15:0];
					REG_STEPS_PER_ROUND: p_steps_per_round = cfg_data;
					REG_START_DIR:       p_start_dir = cfg_data[0];
					REG_ROUND_COUNT:     p_round_count = cfg_data[15:0];
					REG_BASE_INTERVAL:   p_base = cfg_data[15:0];
					default:             ;
				endcase
				// unmapped indexes leave the run alone
				if (cfg_index <= REG_BASE_INTERVAL)
					restart_run();
			end
			if (in_valid && in_ready)
				expected_q.push_back(next_step_decision(now_ms));
		end
		fail_count <= errs;
		open_count <= expected_q.size();
	end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
	import smspg_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_ITEMS = 500;
	localparam logic [2:0] IDX_SPARE_A = 3'd6;
	localparam logic [2:0] IDX_SPARE_B = 3'd7;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_PERIODIC
	} rx_mode_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [2:0]         cfg_index;
	logic [31:0]        cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic [31:0]        now_ms;
	logic               out_valid;
	logic               out_ready;
	logic               step_pulse;
	logic               dir_level;
	logic [31:0]        steps_in_round;
	logic signed [17:0] interval_ms;
	logic               finished;
	int                 fail_count;
	int                 open_count;

	int   cycle_cnt = 0;
	logic hold_req;
	bit   steady;
	int   burst_left;

	sine_modulated_step_pulse_generator dut (.*);
	smspg_checker chk (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// result side: shifting stall patterns, plus one long hold-off on request
	initial begin
		rx_mode_t mode;
		int mode_left, k;
		bit held;
		out_ready <= 1'b0;
		mode = RX_OPEN;
		mode_left = 0;
		held = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req && !held) begin
				out_ready <= 1'b0;
				for (k = 0; k < HOLD_CYCLES; k++)
					@(posedge clk);
				held = 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				case (mode)
					RX_OPEN:   out_ready <= 1'b1;
					RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
					RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
					default:   out_ready <= (mode_left % 5 != 0);
				endcase
			end
		end
	end

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (open_count != 0);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// upper bits of the narrow registers get junk; the block must drop them
	task automatic configure(input cfg_t c);
		logic [15:0] junk;
		junk = 16'($urandom);
		drain();
		write_reg(REG_PHASE_INC, c.phase_increment);
		write_reg(REG_AMPLITUDE, {junk, c.amplitude});
		write_reg(REG_STEPS_PER_ROUND, c.steps_per_round);
		write_reg(REG_START_DIR, {junk, 15'(junk), c.start_direction});
		write_reg(REG_ROUND_COUNT, {~junk, c.round_count});
		write_reg(REG_BASE_INTERVAL, {junk, c.base_interval});
		write_reg($urandom_range(0, 1) ? IDX_SPARE_A : IDX_SPARE_B, $urandom);
		cfg_valid <= 1'b0;
	endtask

	// valid stays up between back-to-back transfers; drops only for a gap
	task automatic send_time(input logic [31:0] t);
		if (!steady && burst_left <= 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		in_valid <= 1'b1;
		now_ms <= t;
		do @(posedge clk); while (!in_ready);
	endtask

	initial begin
		cfg_t c;
		logic signed [15:0] amp;
		logic [31:0] t;
		int sent, span, items, n, k;
		cfg_valid <= 1'b0;
		cfg_index <= REG_PHASE_INC;
		cfg_data <= '0;
		in_valid <= 1'b0;
		now_ms <= '0;
		hold_req <= 1'b0;
		steady = 1'b0;
		burst_left = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// power-up settings; first transfer latches start time
		send_time(32'd0);
		send_time(32'd149);
		send_time(32'd400);
		send_time(32'hFFFF_FFFF);
		send_time(32'h8000_0000);

		// zero steps per round, single round: finished on the first item
		c = '{phase_increment: 32'h0, amplitude: 16'sh7FFF, steps_per_round: 32'd0,
			start_direction: 1'b0, round_count: 16'd0, base_interval: 16'hFFFF};
		configure(c);
		send_time(32'h1234_5678);
		send_time(32'h1234_5679);

		// zero interval, one step per round: each item fires and the direction
		// flips each round until the rounds run out
		c = '{phase_increment: 32'd12345, amplitude: 16'sd0, steps_per_round: 32'd1,
			start_direction: 1'b0, round_count: 16'd3, base_interval: 16'd0};
		configure(c);
		for (n = 0; n < 5; n++)
			send_time(32'd50 + n);

		// quarter turn per ms with full negative amplitude: at a quarter-turn phase the
		// negative interval fires only when time since last step wraps to within 32767 of 2^32
		c = '{phase_increment: 32'h4000_0000, amplitude: -16'sd32768,
			steps_per_round: 32'hFFFF_FFFF, start_direction: 1'b1,
			round_count: 16'hFFFF, base_interval: 16'd0};
		configure(c);
		send_time(32'd1000);
		send_time(32'd1001);
		send_time(32'd993);
		send_time(32'd995);
		send_time(32'h8000_0000);

		// largest interval range
		c = '{phase_increment: 32'hFFFF_FFFF, amplitude: 16'sd32767, steps_per_round: 32'd2,
			start_direction: 1'b1, round_count: 16'hFFFF, base_interval: 16'hFFFF};
		configure(c);
		send_time(32'd7);
		send_time(32'd70007);
		send_time(32'd200007);
		send_time(32'd300007);

		sent = 0;
		n = 0;
		while (sent < RANDOM_ITEMS) begin
			c.phase_increment = ($urandom_range(0, 2) == 0) ? $urandom
				: $urandom_range(0, 32'h00FF_FFFF);
			amp = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 120) - 60);
			c.amplitude = amp;
			c.steps_per_round = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 6);
			c.start_direction = 1'($urandom_range(0, 1));
			c.round_count = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5));
			c.base_interval = ($urandom_range(0, 5) == 0) ? 16'($urandom)
				: 16'($urandom_range(0, 60));
			configure(c);
			// one phase runs flat out against a long output stall
			steady = (n == 2);
			if (n == 2)
				hold_req <= 1'b1;
			span = int'(c.base_interval) + ((amp < 0) ? -int'(amp) : int'(amp)) + 4;
			t = $urandom;
			items = $urandom_range(20, 60);
			for (k = 0; k < items; k++) begin
				case ($urandom_range(0, 9))
					0:       t = $urandom;
					1:       t = t - $urandom_range(1, 100);
					2:       ;
					default: t = t + $urandom_range(0, 2 * span);
				endcase
				send_time(t);
				sent++;
				// unmapped register write must not restart the run
				if ($urandom_range(0, 49) == 0) begin
					drain();
					write_reg($urandom_range(0, 1) ? IDX_SPARE_A : IDX_SPARE_B, $urandom);
					cfg_valid <= 1'b0;
				end
			end
			n++;
		end

		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/smspg_pkg.sv
rtl/smspg_cfg.sv
rtl/smspg_useq.sv
rtl/smspg_dp.sv
rtl/sine_modulated_step_pulse_generator.sv
bench/smspg_checker.sv
bench/tb_top.sv
